>>> rtl/core/drw_pkg.sv
// Shared types, constants and helpers for the depth reprojection warp.
`default_nettype none
package drw_pkg;

    // Configuration register indexes
    typedef enum logic [2:0] {
        CFG_FOCAL_X     = 3'd0,
        CFG_FOCAL_Y     = 3'd1,
        CFG_CENTER_X    = 3'd2,
        CFG_CENTER_Y    = 3'd3,
        CFG_DEPTH_UNIT  = 3'd4,
        CFG_MATRIX_A    = 3'd5,
        CFG_MATRIX_B    = 3'd6,
        CFG_MATRIX_C    = 3'd7
    } t_cfg_idx;

    localparam logic [15:0] RST_FOCAL_X    = 16'd9600;
    localparam logic [15:0] RST_FOCAL_Y    = 16'd9600;
    localparam logic [15:0] RST_CENTER_X   = 16'd5120;
    localparam logic [15:0] RST_CENTER_Y   = 16'd3840;
    localparam logic [31:0] RST_DEPTH_UNIT = 32'd4294967;
    localparam logic [63:0] RST_MATRIX_A   = 64'd4096;
    localparam logic [63:0] RST_MATRIX_B   = 64'd268435456;
    localparam logic [63:0] RST_MATRIX_C   = 64'd17592186044416;

    localparam int NormBits = 32;   // quotient bits of the normalising divide
    localparam int ProjBits = 17;   // quotient bits of the projection divide

    // Normalising divide, one quotient bit per stage
    typedef struct packed {
        logic        ok;
        logic [23:0] colour;
        logic [15:0] mag_x;
        logic [15:0] mag_y;
        logic        neg_x;
        logic        neg_y;
        logic [15:0] rem_x;
        logic [15:0] rem_y;
        logic [31:0] q_x;
        logic [31:0] q_y;
        logic [31:0] z;
    } t_div_a;

    // Projection divide, one quotient bit per stage
    typedef struct packed {
        logic        ok;
        logic [23:0] colour;
        logic        over_x;
        logic        over_y;
        logic        neg_x;
        logic        neg_y;
        logic [53:0] den;
        logic [53:0] rem_x;
        logic [53:0] rem_y;
        logic [16:0] low_x;
        logic [16:0] low_y;
        logic [16:0] q_x;
        logic [16:0] q_y;
    } t_div_b;

    function automatic logic signed [15:0] coef(input logic [63:0] row, input int k);
        coef = row[16*k +: 16];
    endfunction

endpackage
`default_nettype wire

>>> rtl/core/drw_in_if.sv
// Source pixel channel.
`default_nettype none
interface drw_in_if;
    logic        valid;
    logic        ready;
    logic [9:0]  src_column;
    logic [9:0]  src_row;
    logic [15:0] raw_depth;
    logic [23:0] pixel_colour;

    modport source (output valid, src_column, src_row, raw_depth, pixel_colour,
                    input ready);
    modport sink   (input valid, src_column, src_row, raw_depth, pixel_colour,
                    output ready);
endinterface
`default_nettype wire

>>> rtl/core/drw_out_if.sv
// Write command channel.
`default_nettype none
interface drw_out_if;
    logic        valid;
    logic        ready;
    logic [9:0]  dst_column;
    logic [9:0]  dst_row;
    logic [23:0] out_colour;
    logic        write_enable;

    modport source (output valid, dst_column, dst_row, out_colour, write_enable,
                    input ready);
    modport sink   (input valid, dst_column, dst_row, out_colour, write_enable,
                    output ready);
endinterface
`default_nettype wire

>>> rtl/core/depth_reprojection_warp.sv
// Depth reprojection warp: pixel in, pinhole deproject, rigid transform, reproject, write out.
//
// Fully pipelined: one pixel transaction is taken every cycle unless the pipe is
// stalled, and each gives one write command. The pipe is built from the two
// bit-per-stage dividers (32 stages for the normalised coordinates, 17 for the
// projection) plus the multiply stages. Every stage advances together whenever
// the output register is empty or being taken, so a stall holds the whole pipe.
// Items with odd or out-of-frame source positions, zero depth, zero focal length,
// zero transformed depth or a target outside the frame come out with write_enable
// low and zero payload. Configuration must be written only while idle (not enforced).
`default_nettype none
module depth_reprojection_warp #(
    parameter int IMAGE_WIDTH  = 1024,
    parameter int IMAGE_HEIGHT = 1024
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_we,
    input  wire logic [2:0]  i_cfg_index,
    input  wire logic [63:0] i_cfg_data,
    drw_in_if.sink           i_pix,
    drw_out_if.source        o_wr
);

    localparam int NA = drw_pkg::NormBits;
    localparam int NB = drw_pkg::ProjBits;
    localparam logic [12:0] LimW  = 13'(IMAGE_WIDTH);
    localparam logic [12:0] LimH  = 13'(IMAGE_HEIGHT);
    localparam logic [18:0] LimU  = 19'(16 * IMAGE_WIDTH);
    localparam logic [18:0] LimV  = 19'(16 * IMAGE_HEIGHT);

    // ---------------- configuration ----------------
    logic [15:0] r_focal_x, r_focal_y, r_center_x, r_center_y;
    logic [31:0] r_depth_unit;
    logic [63:0] r_mat [3];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_focal_x    <= drw_pkg::RST_FOCAL_X;
            r_focal_y    <= drw_pkg::RST_FOCAL_Y;
            r_center_x   <= drw_pkg::RST_CENTER_X;
            r_center_y   <= drw_pkg::RST_CENTER_Y;
            r_depth_unit <= drw_pkg::RST_DEPTH_UNIT;
            r_mat[0]     <= drw_pkg::RST_MATRIX_A;
            r_mat[1]     <= drw_pkg::RST_MATRIX_B;
            r_mat[2]     <= drw_pkg::RST_MATRIX_C;
        end else if (i_cfg_we) begin
            case (drw_pkg::t_cfg_idx'(i_cfg_index))
                drw_pkg::CFG_FOCAL_X:    r_focal_x    <= i_cfg_data[15:0];
                drw_pkg::CFG_FOCAL_Y:    r_focal_y    <= i_cfg_data[15:0];
                drw_pkg::CFG_CENTER_X:   r_center_x   <= i_cfg_data[15:0];
                drw_pkg::CFG_CENTER_Y:   r_center_y   <= i_cfg_data[15:0];
                drw_pkg::CFG_DEPTH_UNIT: r_depth_unit <= i_cfg_data[31:0];
                drw_pkg::CFG_MATRIX_A:   r_mat[0]     <= i_cfg_data;
                drw_pkg::CFG_MATRIX_B:   r_mat[1]     <= i_cfg_data;
                drw_pkg::CFG_MATRIX_C:   r_mat[2]     <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // ---------------- flow control ----------------
    logic w_adv;
    logic r_ov;
    assign w_adv       = !r_ov || o_wr.ready;
    assign i_pix.ready = w_adv;

    logic       r_va [NA+1];
    logic       r_v1, r_v2, r_v3, r_v4, r_v5;
    logic       r_vb [NB+1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k <= NA; k++) r_va[k] <= 1'b0;
            for (int k = 0; k <= NB; k++) r_vb[k] <= 1'b0;
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
            r_v5 <= 1'b0;
            r_ov <= 1'b0;
        end else if (w_adv) begin
            r_va[0] <= i_pix.valid;
            for (int k = 0; k < NA; k++) r_va[k+1] <= r_va[k];
            r_v1    <= r_va[NA];
            r_v2    <= r_v1;
            r_v3    <= r_v2;
            r_v4    <= r_v3;
            r_v5    <= r_v4;
            r_vb[0] <= r_v5;
            for (int k = 0; k < NB; k++) r_vb[k+1] <= r_vb[k];
            r_ov    <= r_vb[NB];
        end
    end

    // ---------------- entry: qualify, centre offsets, depth scale ----------------
    drw_pkg::t_div_a r_da [NA+1];
    drw_pkg::t_div_a n_da0;
    logic [16:0] w_dx, w_dy, w_dxn, w_dyn;
    logic [47:0] w_zp;

    always_comb begin
        w_dx  = {3'b0, i_pix.src_column, 4'b0} - {1'b0, r_center_x};
        w_dy  = {3'b0, i_pix.src_row, 4'b0} - {1'b0, r_center_y};
        w_dxn = -w_dx;
        w_dyn = -w_dy;
        w_zp  = {32'b0, i_pix.raw_depth} * {16'b0, r_depth_unit};
        n_da0.ok = !i_pix.src_column[0] && !i_pix.src_row[0] &&
                   ({3'b0, i_pix.src_column} < LimW) &&
                   ({3'b0, i_pix.src_row} < LimH) &&
                   (i_pix.raw_depth != 16'd0) && (r_depth_unit != 32'd0) &&
                   (r_focal_x != 16'd0) && (r_focal_y != 16'd0);
        n_da0.colour = i_pix.pixel_colour;
        n_da0.neg_x  = w_dx[16];
        n_da0.neg_y  = w_dy[16];
        n_da0.mag_x  = w_dx[16] ? w_dxn[15:0] : w_dx[15:0];
        n_da0.mag_y  = w_dy[16] ? w_dyn[15:0] : w_dy[15:0];
        n_da0.rem_x  = '0;
        n_da0.rem_y  = '0;
        n_da0.q_x    = '0;
        n_da0.q_y    = '0;
        n_da0.z      = w_zp[47:16];
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) r_da[0] <= n_da0;
    end

    // ---------------- normalising divide: (mag << 16) / focal ----------------
    for (genvar k = 0; k < NA; k++) begin : g_div_a
        drw_pkg::t_div_a n_da;
        logic        w_bx, w_by;
        logic [16:0] w_shx, w_shy;

        always_comb begin
            // numerator is mag followed by sixteen zero bits
            if (k < 16) begin
                w_bx = r_da[k].mag_x[15 - (k % 16)];
                w_by = r_da[k].mag_y[15 - (k % 16)];
            end else begin
                w_bx = 1'b0;
                w_by = 1'b0;
            end
            n_da  = r_da[k];
            w_shx = {r_da[k].rem_x, w_bx};
            w_shy = {r_da[k].rem_y, w_by};
            if (w_shx >= {1'b0, r_focal_x}) begin
                n_da.rem_x = 16'(w_shx - {1'b0, r_focal_x});
                n_da.q_x   = {r_da[k].q_x[NA-2:0], 1'b1};
            end else begin
                n_da.rem_x = w_shx[15:0];
                n_da.q_x   = {r_da[k].q_x[NA-2:0], 1'b0};
            end
            if (w_shy >= {1'b0, r_focal_y}) begin
                n_da.rem_y = 16'(w_shy - {1'b0, r_focal_y});
                n_da.q_y   = {r_da[k].q_y[NA-2:0], 1'b1};
            end else begin
                n_da.rem_y = w_shy[15:0];
                n_da.q_y   = {r_da[k].q_y[NA-2:0], 1'b0};
            end
        end

        always_ff @(posedge i_clk) begin
            if (w_adv) r_da[k+1] <= n_da;
        end
    end

    // ---------------- M1: X = Z*a, Y = Z*b ----------------
    logic        r_m1_ok, r_m1_xn, r_m1_yn;
    logic [23:0] r_m1_colour;
    logic [47:0] r_m1_xm, r_m1_ym;
    logic [31:0] r_m1_z;
    logic [63:0] w_xp, w_yp;

    assign w_xp = {32'b0, r_da[NA].q_x} * {32'b0, r_da[NA].z};
    assign w_yp = {32'b0, r_da[NA].q_y} * {32'b0, r_da[NA].z};

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_m1_ok     <= r_da[NA].ok;
            r_m1_colour <= r_da[NA].colour;
            r_m1_xn     <= r_da[NA].neg_x;
            r_m1_yn     <= r_da[NA].neg_y;
            r_m1_xm     <= w_xp[63:16];
            r_m1_ym     <= w_yp[63:16];
            r_m1_z      <= r_da[NA].z;
        end
    end

    // ---------------- M2: coefficient partial products ----------------
    logic        r_m2_ok;
    logic [23:0] r_m2_colour;
    logic [39:0] r_m2_lo [9];
    logic [39:0] r_m2_hi [9];
    logic        r_m2_ng [9];
    logic [39:0] n_m2_lo [9];
    logic [39:0] n_m2_hi [9];
    logic        n_m2_ng [9];

    always_comb begin
        logic signed [15:0] m;
        logic [15:0]        mm;
        logic [47:0]        v;
        logic               vn;
        for (int r = 0; r < 3; r++) begin
            for (int k = 0; k < 3; k++) begin
                m  = drw_pkg::coef(r_mat[r], k);
                mm = m[15] ? 16'(-m) : 16'(m);
                case (k)
                    0:       begin v = r_m1_xm;          vn = r_m1_xn; end
                    1:       begin v = r_m1_ym;          vn = r_m1_yn; end
                    default: begin v = {16'b0, r_m1_z};  vn = 1'b0;    end
                endcase
                n_m2_lo[r*3+k] = {24'b0, mm} * {16'b0, v[23:0]};
                n_m2_hi[r*3+k] = {24'b0, mm} * {16'b0, v[47:24]};
                n_m2_ng[r*3+k] = m[15] ^ vn;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_m2_ok     <= r_m1_ok;
            r_m2_colour <= r_m1_colour;
            r_m2_lo     <= n_m2_lo;
            r_m2_hi     <= n_m2_hi;
            r_m2_ng     <= n_m2_ng;
        end
    end

    // ---------------- M3: assemble, truncate each product, apply sign ----------------
    logic        r_m3_ok;
    logic [23:0] r_m3_colour;
    logic [52:0] r_m3_t [9];
    logic [52:0] n_m3_t [9];

    always_comb begin
        logic [63:0] p;
        for (int i = 0; i < 9; i++) begin
            p = {r_m2_hi[i], 24'b0} + {24'b0, r_m2_lo[i]};
            n_m3_t[i] = r_m2_ng[i] ? -{1'b0, p[63:12]} : {1'b0, p[63:12]};
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_m3_ok     <= r_m2_ok;
            r_m3_colour <= r_m2_colour;
            r_m3_t      <= n_m3_t;
        end
    end

    // ---------------- M4: row sums plus translation ----------------
    logic        r_m4_ok;
    logic [23:0] r_m4_colour;
    logic [54:0] r_m4_p [3];
    logic [54:0] n_m4_p [3];

    always_comb begin
        logic signed [15:0] m3;
        for (int r = 0; r < 3; r++) begin
            m3 = drw_pkg::coef(r_mat[r], 3);
            n_m4_p[r] = {{2{r_m3_t[r*3][52]}},   r_m3_t[r*3]}
                      + {{2{r_m3_t[r*3+1][52]}}, r_m3_t[r*3+1]}
                      + {{2{r_m3_t[r*3+2][52]}}, r_m3_t[r*3+2]}
                      + {{35{m3[15]}}, m3, 4'b0};
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_m4_ok     <= r_m3_ok && (n_m4_p[2] != 55'd0);
            r_m4_colour <= r_m3_colour;
            r_m4_p      <= n_m4_p;
        end
    end

    // ---------------- M5: magnitudes and numerator * focal partials ----------------
    logic        r_m5_ok, r_m5_nx, r_m5_ny;
    logic [23:0] r_m5_colour;
    logic [53:0] r_m5_d;
    logic [42:0] r_m5_xlo, r_m5_xhi, r_m5_ylo, r_m5_yhi;
    logic [54:0] w_nxn, w_nyn, w_dn;
    logic [53:0] w_nx, w_ny, w_d;

    always_comb begin
        w_nxn = -r_m4_p[0];
        w_nyn = -r_m4_p[1];
        w_dn  = -r_m4_p[2];
        w_nx  = r_m4_p[0][54] ? w_nxn[53:0] : r_m4_p[0][53:0];
        w_ny  = r_m4_p[1][54] ? w_nyn[53:0] : r_m4_p[1][53:0];
        w_d   = r_m4_p[2][54] ? w_dn[53:0]  : r_m4_p[2][53:0];
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_m5_ok     <= r_m4_ok;
            r_m5_colour <= r_m4_colour;
            r_m5_nx     <= r_m4_p[0][54] ^ r_m4_p[2][54];
            r_m5_ny     <= r_m4_p[1][54] ^ r_m4_p[2][54];
            r_m5_d      <= w_d;
            r_m5_xlo    <= {16'b0, w_nx[26:0]}  * {27'b0, r_focal_x};
            r_m5_xhi    <= {16'b0, w_nx[53:27]} * {27'b0, r_focal_x};
            r_m5_ylo    <= {16'b0, w_ny[26:0]}  * {27'b0, r_focal_y};
            r_m5_yhi    <= {16'b0, w_ny[53:27]} * {27'b0, r_focal_y};
        end
    end

    // ---------------- M6: full numerator, overflow check, divide setup ----------------
    drw_pkg::t_div_b r_db [NB+1];
    drw_pkg::t_div_b n_db0;
    logic [69:0] w_numx, w_numy;

    always_comb begin
        w_numx = {r_m5_xhi, 27'b0} + {27'b0, r_m5_xlo};
        w_numy = {r_m5_yhi, 27'b0} + {27'b0, r_m5_ylo};
        n_db0.ok     = r_m5_ok;
        n_db0.colour = r_m5_colour;
        n_db0.neg_x  = r_m5_nx;
        n_db0.neg_y  = r_m5_ny;
        n_db0.den    = r_m5_d;
        // a quotient of 2^17 or more lands outside any frame
        n_db0.over_x = {1'b0, w_numx[69:17]} >= r_m5_d;
        n_db0.over_y = {1'b0, w_numy[69:17]} >= r_m5_d;
        n_db0.rem_x  = {1'b0, w_numx[69:17]};
        n_db0.rem_y  = {1'b0, w_numy[69:17]};
        n_db0.low_x  = w_numx[16:0];
        n_db0.low_y  = w_numy[16:0];
        n_db0.q_x    = '0;
        n_db0.q_y    = '0;
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) r_db[0] <= n_db0;
    end

    // ---------------- projection divide ----------------
    for (genvar j = 0; j < NB; j++) begin : g_div_b
        drw_pkg::t_div_b n_db;
        logic [54:0] w_shx, w_shy;

        always_comb begin
            n_db  = r_db[j];
            w_shx = {r_db[j].rem_x, r_db[j].low_x[NB-1-j]};
            w_shy = {r_db[j].rem_y, r_db[j].low_y[NB-1-j]};
            if (w_shx >= {1'b0, r_db[j].den}) begin
                n_db.rem_x = 54'(w_shx - {1'b0, r_db[j].den});
                n_db.q_x   = {r_db[j].q_x[NB-2:0], 1'b1};
            end else begin
                n_db.rem_x = w_shx[53:0];
                n_db.q_x   = {r_db[j].q_x[NB-2:0], 1'b0};
            end
            if (w_shy >= {1'b0, r_db[j].den}) begin
                n_db.rem_y = 54'(w_shy - {1'b0, r_db[j].den});
                n_db.q_y   = {r_db[j].q_y[NB-2:0], 1'b1};
            end else begin
                n_db.rem_y = w_shy[53:0];
                n_db.q_y   = {r_db[j].q_y[NB-2:0], 1'b0};
            end
        end

        always_ff @(posedge i_clk) begin
            if (w_adv) r_db[j+1] <= n_db;
        end
    end

    // ---------------- output: recentre, range check ----------------
    logic [17:0] w_tx, w_ty;
    logic [18:0] w_u, w_v;
    logic        w_we;
    logic [9:0]  r_dst_col, r_dst_row;
    logic [23:0] r_colour;
    logic        r_we;

    always_comb begin
        w_tx = r_db[NB].neg_x ? -{1'b0, r_db[NB].q_x} : {1'b0, r_db[NB].q_x};
        w_ty = r_db[NB].neg_y ? -{1'b0, r_db[NB].q_y} : {1'b0, r_db[NB].q_y};
        w_u  = {w_tx[17], w_tx} + {3'b0, r_center_x};
        w_v  = {w_ty[17], w_ty} + {3'b0, r_center_y};
        w_we = r_db[NB].ok && !r_db[NB].over_x && !r_db[NB].over_y &&
               !w_u[18] && (w_u < LimU) && !w_v[18] && (w_v < LimV);
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_we      <= w_we;
            r_dst_col <= w_we ? w_u[13:4] : 10'd0;
            r_dst_row <= w_we ? w_v[13:4] : 10'd0;
            r_colour  <= w_we ? r_db[NB].colour : 24'd0;
        end
    end

    assign o_wr.valid        = r_ov;
    assign o_wr.dst_column   = r_dst_col;
    assign o_wr.dst_row      = r_dst_row;
    assign o_wr.out_colour   = r_colour;
    assign o_wr.write_enable = r_we;

endmodule
`default_nettype wire
